// ----- sv/tafa_pkg.sv -----
// Package for the texture atlas first-fit allocator.
// Holds sizes, mode and status codes, the controller state type and the command and status structs.
package tafa_pkg;
   localparam int MaxEntries = 1024;
   localparam int AtlasSide  = 1024;
   localparam int GridStep   = 16;
   localparam int IdxW       = $clog2(MaxEntries);
   localparam int CntW       = $clog2(MaxEntries + 1);
   localparam int PosW       = $clog2(AtlasSide + 1);

   localparam logic [1:0] ModeAlloc  = 2'd0;
   localparam logic [1:0] ModeLookup = 2'd1;
   localparam logic [1:0] ModeBounds = 2'd2;

   localparam logic [1:0] StatOk       = 2'd0;
   localparam logic [1:0] StatFull     = 2'd1;
   localparam logic [1:0] StatNotFound = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_CHECK, ST_NEXT_POS, ST_WRITE, ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request, clear scan
      logic idx_clear;  // restart entry scan
      logic idx_step;   // advance entry index
      logic pos_step;   // advance grid position
      logic write;      // store new entry
      logic set_miss;   // result: not found / full
      logic set_hit;    // result from current entry
      logic set_alloc;  // result from allocation
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] mode;
      logic       table_full;
      logic       idx_end;     // index at entry count
      logic       match;       // current entry matches
      logic       pos_valid;   // current position inside atlas
   } stat_type;
endpackage

// ----- sv/texture_atlas_first_fit_allocator.sv -----
// One item at a time. Lookup and bounds walk the stored entries, each entry
// read through the single table read port (READ) and then checked (CHECK).
// Allocate repeats that walk for every grid position it rejects (row by
// row, 16 texels apart), stopping at the first overlapping entry, so it
// slows as the atlas fills. The table needs no clearing after reset.
// Uses tafa_pkg, tafa_control, tafa_datapath.
module texture_atlas_first_fit_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [10:0] req_rect_width,
   input  logic [10:0] req_rect_height,
   input  logic [31:0] req_content_hash,
   input  logic [10:0] req_query_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [10:0] rsp_result_id,
   output logic [9:0]  rsp_place_x,
   output logic [9:0]  rsp_place_y,
   output logic [31:0] rsp_packed_bounds
);
   tafa_pkg::cmd_type  cmd;
   tafa_pkg::stat_type stat;

   tafa_control u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .cmd, .stat
   );

   tafa_datapath u_dp (
      .clock, .reset, .cmd, .stat,
      .req_mode, .req_rect_width, .req_rect_height, .req_content_hash, .req_query_id,
      .res_status(rsp_status), .res_id(rsp_result_id), .res_x(rsp_place_x),
      .res_y(rsp_place_y), .res_bounds(rsp_packed_bounds)
   );

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken while result pending");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= tafa_pkg::StatNotFound)) else $error("bad status");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != tafa_pkg::StatOk) |-> (rsp_result_id == 11'd0 &&
      rsp_packed_bounds == 32'd0)) else $error("miss carries data");
endmodule

// ----- sv/tafa_datapath.sv -----
// Datapath of the allocator: entry tables, scan index, grid position, result.
// Uses tafa_pkg.
module tafa_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  tafa_pkg::cmd_type    cmd,
   output tafa_pkg::stat_type   stat,
   input  logic [1:0]           req_mode,
   input  logic [10:0]          req_rect_width,
   input  logic [10:0]          req_rect_height,
   input  logic [31:0]          req_content_hash,
   input  logic [10:0]          req_query_id,
   output logic [1:0]           res_status,
   output logic [10:0]          res_id,
   output logic [9:0]           res_x,
   output logic [9:0]           res_y,
   output logic [31:0]          res_bounds
);
   localparam int EntW = 10 + 10 + 11 + 11 + 32 + 11;

   logic [EntW-1:0] mem [tafa_pkg::MaxEntries];
   logic [EntW-1:0] rd_ff;

   logic [1:0]  mode_ff;
   logic [10:0] w_ff, h_ff, qid_ff;
   logic [31:0] hash_ff;
   logic [tafa_pkg::CntW-1:0] count_ff, count_in, idx_ff, idx_in;
   logic [10:0] next_id_ff, next_id_in;
   logic [tafa_pkg::PosW-1:0] x_ff, x_in, y_ff, y_in;
   logic [1:0]  status_ff;
   logic [10:0] id_ff;
   logic [9:0]  px_ff, py_ff;
   logic [31:0] bounds_ff;

   logic [9:0]  e_x, e_y;
   logic [10:0] e_w, e_h, e_id;
   logic [31:0] e_hash;
   assign {e_x, e_y, e_w, e_h, e_hash, e_id} = rd_ff;

   // overlap test, 13-bit sums hold atlas plus width
   logic [12:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
   logic overlap, x_fits, y_fits;
   always_comb begin
      ax0 = 13'(x_ff);
      ay0 = 13'(y_ff);
      ax1 = 13'(x_ff) + 13'(w_ff);
      ay1 = 13'(y_ff) + 13'(h_ff);
      bx0 = 13'(e_x);
      by0 = 13'(e_y);
      bx1 = 13'(e_x) + 13'(e_w);
      by1 = 13'(e_y) + 13'(e_h);
      overlap = (ax0 < bx1) && (bx0 < ax1) && (ay0 < by1) && (by0 < ay1)
                && (ax0 < ax1) && (bx0 < bx1) && (ay0 < ay1) && (by0 < by1);
      x_fits = (ax1 <= 13'(tafa_pkg::AtlasSide)) && (x_ff < tafa_pkg::PosW'(tafa_pkg::AtlasSide));
      y_fits = (ay1 <= 13'(tafa_pkg::AtlasSide)) && (y_ff < tafa_pkg::PosW'(tafa_pkg::AtlasSide));
   end

   always_comb begin
      stat.mode       = mode_ff;
      stat.table_full = (count_ff == tafa_pkg::CntW'(tafa_pkg::MaxEntries));
      stat.idx_end    = (idx_ff == count_ff);
      stat.pos_valid  = x_fits && y_fits;
      case (mode_ff)
         tafa_pkg::ModeAlloc:  stat.match = overlap;
         tafa_pkg::ModeLookup: stat.match = (e_hash == hash_ff);
         tafa_pkg::ModeBounds: stat.match = (e_id == qid_ff);
         default:              stat.match = 1'b0;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load || cmd.idx_clear) idx_in = '0;
      else if (cmd.idx_step) idx_in = idx_ff + 1'b1;
      x_in = x_ff;
      y_in = y_ff;
      if (cmd.load) begin
         x_in = '0;
         y_in = '0;
      end else if (cmd.pos_step) begin
         // wrap to next row when the next column no longer fits
         if ((13'(x_ff) + 13'(tafa_pkg::GridStep) + 13'(w_ff) > 13'(tafa_pkg::AtlasSide))
             || (x_ff + tafa_pkg::PosW'(tafa_pkg::GridStep)
                 >= tafa_pkg::PosW'(tafa_pkg::AtlasSide))) begin
            x_in = '0;
            y_in = y_ff + tafa_pkg::PosW'(tafa_pkg::GridStep);
         end else begin
            x_in = x_ff + tafa_pkg::PosW'(tafa_pkg::GridStep);
         end
      end
      count_in   = cmd.write ? count_ff + 1'b1 : count_ff;
      next_id_in = cmd.write ? next_id_ff + 1'b1 : next_id_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         next_id_ff <= 11'd1;
      end else begin
         count_ff   <= count_in;
         next_id_ff <= next_id_in;
      end
      idx_ff <= idx_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      if (cmd.load) begin
         mode_ff <= req_mode;
         w_ff    <= req_rect_width;
         h_ff    <= req_rect_height;
         hash_ff <= req_content_hash;
         qid_ff  <= req_query_id;
      end
      if (cmd.write)
         mem[count_ff[tafa_pkg::IdxW-1:0]] <= {x_ff[9:0], y_ff[9:0], w_ff, h_ff, hash_ff,
                                              next_id_ff};
      rd_ff <= mem[idx_ff[tafa_pkg::IdxW-1:0]];
      if (cmd.set_miss) begin
         status_ff <= (mode_ff == tafa_pkg::ModeAlloc) ? tafa_pkg::StatFull
                                                      : tafa_pkg::StatNotFound;
         id_ff     <= '0;
         px_ff     <= '0;
         py_ff     <= '0;
         bounds_ff <= '0;
      end else if (cmd.set_hit) begin
         status_ff <= tafa_pkg::StatOk;
         id_ff     <= (mode_ff == tafa_pkg::ModeBounds) ? qid_ff : e_id;
         px_ff     <= '0;
         py_ff     <= '0;
         bounds_ff <= (mode_ff == tafa_pkg::ModeBounds)
                      ? {8'(e_h >> 4), 8'(e_w >> 4), 8'(e_y >> 4), 8'(e_x >> 4)} : 32'd0;
      end else if (cmd.set_alloc) begin
         status_ff <= tafa_pkg::StatOk;
         id_ff     <= next_id_ff;
         px_ff     <= x_ff[9:0];
         py_ff     <= y_ff[9:0];
         bounds_ff <= '0;
      end
   end

   assign res_status = status_ff;
   assign res_id     = id_ff;
   assign res_x      = px_ff;
   assign res_y      = py_ff;
   assign res_bounds = bounds_ff;
endmodule

// ----- sv/tafa_control.sv -----
// Controller of the allocator: sequences scans and the result handshake.
// Uses tafa_pkg.
module tafa_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tafa_pkg::cmd_type    cmd,
   input  tafa_pkg::stat_type   stat
);
   tafa_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tafa_pkg::ST_IDLE: if (req_valid) state_in = tafa_pkg::ST_READ;
         tafa_pkg::ST_READ: begin
            if (stat.mode == tafa_pkg::ModeAlloc) begin
               if (stat.table_full || !stat.pos_valid) state_in = tafa_pkg::ST_DONE;
               else if (stat.idx_end) state_in = tafa_pkg::ST_WRITE;
               else state_in = tafa_pkg::ST_CHECK;
            end else if (stat.mode == tafa_pkg::ModeLookup ||
                         stat.mode == tafa_pkg::ModeBounds) begin
               state_in = stat.idx_end ? tafa_pkg::ST_DONE : tafa_pkg::ST_CHECK;
            end else begin
               state_in = tafa_pkg::ST_DONE;
            end
         end
         tafa_pkg::ST_CHECK: begin
            if (stat.mode == tafa_pkg::ModeAlloc)
               state_in = stat.match ? tafa_pkg::ST_NEXT_POS : tafa_pkg::ST_READ;
            else
               state_in = stat.match ? tafa_pkg::ST_DONE : tafa_pkg::ST_READ;
         end
         tafa_pkg::ST_NEXT_POS: state_in = tafa_pkg::ST_READ;
         tafa_pkg::ST_WRITE:    state_in = tafa_pkg::ST_DONE;
         tafa_pkg::ST_DONE:     if (!rsp_stall) state_in = tafa_pkg::ST_IDLE;
         default:               state_in = tafa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != tafa_pkg::ST_IDLE);
      rsp_valid = (state_ff == tafa_pkg::ST_DONE);
      case (state_ff)
         tafa_pkg::ST_IDLE: cmd.load = req_valid;
         tafa_pkg::ST_READ: begin
            if (stat.mode == tafa_pkg::ModeAlloc) begin
               if (stat.table_full || !stat.pos_valid) cmd.set_miss = 1'b1;
            end else if (stat.mode == tafa_pkg::ModeLookup ||
                         stat.mode == tafa_pkg::ModeBounds) begin
               cmd.set_miss = stat.idx_end;
            end else begin
               cmd.set_miss = 1'b1;
            end
            cmd.idx_step = !stat.idx_end;
         end
         tafa_pkg::ST_CHECK: begin
            if (stat.mode == tafa_pkg::ModeAlloc) cmd.pos_step = stat.match;
            else cmd.set_hit = stat.match;
         end
         tafa_pkg::ST_NEXT_POS: cmd.idx_clear = 1'b1;
         tafa_pkg::ST_WRITE: begin
            cmd.write     = 1'b1;
            cmd.set_alloc = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= tafa_pkg::ST_IDLE;
      else state_ff <= state_in;
   end
endmodule
